@@ hw/rtl/nwsp_pkg.sv @@
// shared types and constants for the negative-weight shortest path unit
package nwsp_pkg;

  // field widths
  localparam int VERT_W   = 5;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 24;
  localparam int POT_W    = 24;
  localparam int TD_W     = 25;
  localparam int EDGE_W   = 2 * VERT_W + WEIGHT_W;
  localparam int VCNT_W   = 6;
  localparam int PATH_D   = 32;
  localparam int LEN_W    = 6;

  // edge word layout: tail, head, weight
  localparam int TAIL_LSB = VERT_W + WEIGHT_W;
  localparam int HEAD_LSB = WEIGHT_W;

  // opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNREACH = 2'd1;
  localparam logic [1:0] ST_NEGCYC  = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  // datapath commands
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_SET_BAD,
    CMD_SET_NEGCYC,
    CMD_SET_UNREACH,
    CMD_BF_START,
    CMD_POT_CLEAR,
    CMD_PASS_START,
    CMD_PASS_NEXT,
    CMD_EDGE_READ,
    CMD_POT_READ,
    CMD_BF_RELAX,
    CMD_DJ_INIT,
    CMD_SCAN_START,
    CMD_SCAN_READ,
    CMD_SCAN_CMP,
    CMD_PICK,
    CMD_HEAD_READ,
    CMD_RELAX,
    CMD_PATH_READ,
    CMD_DIST,
    CMD_WALK,
    CMD_WALK_NEXT,
    CMD_EMIT_READ,
    CMD_EMIT_LOAD
  } cmd_t;

  // datapath status back to the controller
  typedef struct packed {
    logic bad;
    logic v_last;
    logic k_end;
    logic improve;
    logic pass_final;
    logic changed;
    logic scan_last;
    logic found;
    logic unreached;
    logic walk_done;
    logic out_last;
  } dp_stat_t;

endpackage

@@ hw/rtl/negative_weight_shortest_path_unit.sv @@
// top level of the negative-weight shortest path unit
//
//   port group   direction  handshake           word
//   in_*         input      in_valid/in_stall   opcode, from/to vertex, weight
//   out_*        output     out_valid/out_stall status, distance, path vertex, last
//   cfg_*        input      cfg_wr_en           vertex count
//
// clear and add are taken in idle without raising in_stall; opcode 3 is accepted and dropped
// a query runs at most n+1 bellman-ford passes and at most n dijkstra rounds, with n
// vertices, then walks and emits the path; each pass and round reads the E stored
// edges one at a time from the single-port edge table; output stalls hold the emit
// a status word and its out_valid are registered by the state whose check gives it
// reset is synchronous and active low; no clearing pass is needed
// in_stall is high from query start until its last word is taken; a stalled
// output word holds in its register
module negative_weight_shortest_path_unit #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_opcode,
  input  logic [nwsp_pkg::VERT_W-1:0]          in_from_vertex,
  input  logic [nwsp_pkg::VERT_W-1:0]          in_to_vertex,
  input  logic signed [nwsp_pkg::WEIGHT_W-1:0] in_weight,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_status,
  output logic signed [nwsp_pkg::DIST_W-1:0]   out_distance,
  output logic [nwsp_pkg::VERT_W-1:0]          out_path_vertex,
  output logic                                 out_last,
  input  logic                                 cfg_wr_en,
  input  logic [nwsp_pkg::VCNT_W-1:0]          cfg_vertex_count
);

  nwsp_pkg::cmd_t     cmd;
  nwsp_pkg::dp_stat_t stat;

  // sequencer
  nwsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .out_stall (out_stall),
    .stat      (stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // storage and arithmetic
  nwsp_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_opcode        (in_opcode),
    .in_from_vertex   (in_from_vertex),
    .in_to_vertex     (in_to_vertex),
    .in_weight        (in_weight),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_vertex_count (cfg_vertex_count),
    .out_status       (out_status),
    .out_distance     (out_distance),
    .out_path_vertex  (out_path_vertex),
    .out_last         (out_last),
    .stat             (stat)
  );

  // no new word is taken while a result word is pending
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input taken while result pending");

  // a query blocks the input on the next cycle
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_opcode == nwsp_pkg::OP_QUERY) |=> in_stall)
    else $error("query did not block input");

  // error results are single, final and zero
  a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != nwsp_pkg::ST_OK) |->
      (out_last && out_distance == '0 && out_path_vertex == '0))
    else $error("malformed status word");

endmodule

@@ hw/rtl/nwsp_datapath.sv @@
// edge table, vertex stores, arithmetic and result registers
module nwsp_datapath #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 256
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  nwsp_pkg::cmd_t                         cmd,
  input  logic [1:0]                             in_opcode,
  input  logic [nwsp_pkg::VERT_W-1:0]            in_from_vertex,
  input  logic [nwsp_pkg::VERT_W-1:0]            in_to_vertex,
  input  logic signed [nwsp_pkg::WEIGHT_W-1:0]   in_weight,
  input  logic                                   cfg_wr_en,
  input  logic [nwsp_pkg::VCNT_W-1:0]            cfg_vertex_count,
  output logic [1:0]                             out_status,
  output logic signed [nwsp_pkg::DIST_W-1:0]     out_distance,
  output logic [nwsp_pkg::VERT_W-1:0]            out_path_vertex,
  output logic                                   out_last,
  output nwsp_pkg::dp_stat_t                     stat
);

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int NW   = $clog2(MAX_VERTICES + 1);
  localparam int IW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW   = $clog2(MAX_EDGES + 1);
  localparam int CNTW = (NW > nwsp_pkg::VCNT_W) ? NW : nwsp_pkg::VCNT_W;
  localparam int PW   = nwsp_pkg::POT_W;
  localparam int TW   = nwsp_pkg::TD_W;
  localparam int BW   = nwsp_pkg::TD_W + 2;

  // stores
  logic [nwsp_pkg::EDGE_W-1:0] edge_mem [MAX_EDGES];
  logic signed [PW-1:0]        pot_mem  [MAX_VERTICES];
  logic signed [TW-1:0]        td_mem   [MAX_VERTICES];
  logic [VW-1:0]               pred_mem [MAX_VERTICES];
  logic [nwsp_pkg::VERT_W-1:0] path_mem [nwsp_pkg::PATH_D];

  // control registers
  logic [CW-1:0]                  edge_total_r;
  logic                           overflow_r;
  logic [nwsp_pkg::VCNT_W-1:0]    vcount_r;

  // working registers
  logic [nwsp_pkg::EDGE_W-1:0]    edge_q_r;
  logic [CW-1:0]                  k_r;
  logic [VW-1:0]                  v_r;
  logic [VW-1:0]                  vq_r;
  logic [NW-1:0]                  pass_r;
  logic                           changed_r;
  logic                           found_r;
  logic [VW-1:0]                  best_r;
  logic signed [TW-1:0]           best_d_r;
  logic [VW-1:0]                  u_r;
  logic signed [TW-1:0]           tdu_r;
  logic signed [PW-1:0]           pot_a_q_r;
  logic signed [PW-1:0]           pot_b_q_r;
  logic signed [TW-1:0]           td_q_r;
  logic [VW-1:0]                  pred_q_r;
  logic signed [BW-1:0]           base_r;
  logic                           in_rng_r;
  logic                           relax_ok_r;
  logic [MAX_VERTICES-1:0]        reached_r;
  logic [MAX_VERTICES-1:0]        fin_r;
  logic [nwsp_pkg::VERT_W-1:0]    src_r;
  logic [nwsp_pkg::VERT_W-1:0]    dst_r;
  logic [nwsp_pkg::VERT_W-1:0]    cur_r;
  logic [nwsp_pkg::LEN_W-1:0]     len_r;
  logic signed [nwsp_pkg::DIST_W-1:0] dist_r;
  logic [nwsp_pkg::VERT_W-1:0]    pv_q_r;
  logic [1:0]                     out_status_r;
  logic signed [nwsp_pkg::DIST_W-1:0] out_distance_r;
  logic [nwsp_pkg::VERT_W-1:0]    out_path_vertex_r;
  logic                           out_last_r;

  // decoded fields and derived values
  logic [nwsp_pkg::VERT_W-1:0]    e_tail;
  logic [nwsp_pkg::VERT_W-1:0]    e_head;
  logic signed [nwsp_pkg::WEIGHT_W-1:0] e_w;
  logic [VW-1:0]                  tail_ix;
  logic [VW-1:0]                  head_ix;
  logic [CNTW-1:0]                n_w;
  logic [CNTW-1:0]                lim_w;
  logic signed [PW:0]             cand;
  logic                           improve;
  logic signed [BW-1:0]           nd;
  logic                           relax_hit;
  logic                           scan_take;
  logic                           table_full;

  assign e_tail  = edge_q_r[nwsp_pkg::TAIL_LSB +: nwsp_pkg::VERT_W];
  assign e_head  = edge_q_r[nwsp_pkg::HEAD_LSB +: nwsp_pkg::VERT_W];
  assign e_w     = $signed(edge_q_r[nwsp_pkg::WEIGHT_W-1:0]);
  assign tail_ix = VW'(e_tail);
  assign head_ix = VW'(e_head);

  // effective vertex count and path length limit
  always_comb begin
    if (CNTW'(vcount_r) < CNTW'(MAX_VERTICES)) begin
      n_w = CNTW'(vcount_r);
    end else begin
      n_w = CNTW'(MAX_VERTICES);
    end
    if (n_w > CNTW'(nwsp_pkg::PATH_D)) begin
      lim_w = CNTW'(nwsp_pkg::PATH_D);
    end else begin
      lim_w = n_w;
    end
  end

  assign table_full = (edge_total_r == CW'(MAX_EDGES));

  // bellman-ford candidate
  assign cand    = (PW+1)'(pot_a_q_r) + (PW+1)'(e_w);
  assign improve = in_rng_r && (cand < (PW+1)'(pot_b_q_r));

  // dijkstra relaxation on reweighted edge
  assign nd        = base_r - BW'(pot_b_q_r);
  assign relax_hit = relax_ok_r && (!reached_r[head_ix] || (nd < BW'(td_q_r)));

  // minimum scan, ties go to the higher index
  assign scan_take = reached_r[vq_r] && !fin_r[vq_r] && (!found_r || (td_q_r <= best_d_r));

  // status to controller, query vertices come from the registered word
  always_comb begin
    stat.bad        = overflow_r || (CNTW'(src_r) >= n_w)
                      || (CNTW'(dst_r) >= n_w);
    stat.v_last     = (CNTW'(v_r) == n_w - CNTW'(1));
    stat.k_end      = (k_r == edge_total_r);
    stat.improve    = improve;
    stat.pass_final = (CNTW'(pass_r) == n_w);
    stat.changed    = changed_r;
    stat.scan_last  = (CNTW'(vq_r) == n_w - CNTW'(1));
    stat.found      = found_r;
    stat.unreached  = !reached_r[VW'(dst_r)];
    stat.walk_done  = (cur_r == src_r) || ((CNTW'(len_r) + CNTW'(1)) >= lim_w);
    stat.out_last   = out_last_r;
  end

  // configuration and edge table bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_total_r <= '0;
      overflow_r   <= 1'b0;
      vcount_r     <= nwsp_pkg::VCNT_W'(32);
    end else begin
      if (cfg_wr_en) begin
        vcount_r <= cfg_vertex_count;
      end
      if (cmd == nwsp_pkg::CMD_ACCEPT) begin
        if (in_opcode == nwsp_pkg::OP_CLEAR) begin
          edge_total_r <= '0;
          overflow_r   <= 1'b0;
        end else if (in_opcode == nwsp_pkg::OP_ADD) begin
          if (table_full) begin
            overflow_r <= 1'b1;
          end else begin
            edge_total_r <= edge_total_r + CW'(1);
          end
        end
      end
    end
  end

  // edge table write and read
  always_ff @(posedge clk) begin
    if (cmd == nwsp_pkg::CMD_ACCEPT && in_opcode == nwsp_pkg::OP_ADD && !table_full) begin
      edge_mem[edge_total_r[IW-1:0]] <= {in_from_vertex, in_to_vertex, in_weight};
    end
    if (cmd == nwsp_pkg::CMD_EDGE_READ) begin
      edge_q_r <= edge_mem[k_r[IW-1:0]];
    end
  end

  // potential store: one write port, two read ports
  always_ff @(posedge clk) begin
    if (cmd == nwsp_pkg::CMD_POT_CLEAR) begin
      pot_mem[v_r] <= '0;
    end else if (cmd == nwsp_pkg::CMD_BF_RELAX && improve) begin
      pot_mem[head_ix] <= cand[PW-1:0];
    end
    case (cmd)
      nwsp_pkg::CMD_POT_READ: begin
        pot_a_q_r <= pot_mem[tail_ix];
        pot_b_q_r <= pot_mem[head_ix];
      end
      nwsp_pkg::CMD_PICK: begin
        pot_a_q_r <= pot_mem[best_r];
      end
      nwsp_pkg::CMD_HEAD_READ: begin
        pot_b_q_r <= pot_mem[head_ix];
      end
      nwsp_pkg::CMD_PATH_READ: begin
        pot_a_q_r <= pot_mem[VW'(src_r)];
        pot_b_q_r <= pot_mem[VW'(dst_r)];
      end
      default: begin
      end
    endcase
  end

  // tentative distance store
  always_ff @(posedge clk) begin
    if (cmd == nwsp_pkg::CMD_DJ_INIT) begin
      td_mem[VW'(src_r)] <= '0;
    end else if (cmd == nwsp_pkg::CMD_RELAX && relax_hit) begin
      td_mem[head_ix] <= nd[TW-1:0];
    end
    case (cmd)
      nwsp_pkg::CMD_SCAN_READ: td_q_r <= td_mem[v_r];
      nwsp_pkg::CMD_HEAD_READ: td_q_r <= td_mem[head_ix];
      nwsp_pkg::CMD_PATH_READ: td_q_r <= td_mem[VW'(dst_r)];
      default: begin
      end
    endcase
  end

  // predecessor store
  always_ff @(posedge clk) begin
    if (cmd == nwsp_pkg::CMD_RELAX && relax_hit) begin
      pred_mem[head_ix] <= u_r;
    end
    if (cmd == nwsp_pkg::CMD_WALK) begin
      pred_q_r <= pred_mem[VW'(cur_r)];
    end
  end

  // path buffer, written target first and read back source first
  always_ff @(posedge clk) begin
    if (cmd == nwsp_pkg::CMD_WALK) begin
      path_mem[len_r[nwsp_pkg::VERT_W-1:0]] <= cur_r;
    end
    if (cmd == nwsp_pkg::CMD_EMIT_READ) begin
      pv_q_r <= path_mem[nwsp_pkg::VERT_W'(len_r - nwsp_pkg::LEN_W'(1))];
    end
  end

  // sequencing counters and search registers
  always_ff @(posedge clk) begin
    case (cmd)
      nwsp_pkg::CMD_ACCEPT: begin
        src_r <= in_from_vertex;
        dst_r <= in_to_vertex;
      end
      nwsp_pkg::CMD_SET_BAD: begin
        out_status_r      <= nwsp_pkg::ST_BAD;
        out_distance_r    <= '0;
        out_path_vertex_r <= '0;
        out_last_r        <= 1'b1;
      end
      nwsp_pkg::CMD_SET_NEGCYC: begin
        out_status_r      <= nwsp_pkg::ST_NEGCYC;
        out_distance_r    <= '0;
        out_path_vertex_r <= '0;
        out_last_r        <= 1'b1;
      end
      nwsp_pkg::CMD_SET_UNREACH: begin
        out_status_r      <= nwsp_pkg::ST_UNREACH;
        out_distance_r    <= '0;
        out_path_vertex_r <= '0;
        out_last_r        <= 1'b1;
      end
      nwsp_pkg::CMD_BF_START: begin
        v_r    <= '0;
        pass_r <= '0;
      end
      nwsp_pkg::CMD_POT_CLEAR: begin
        v_r <= v_r + VW'(1);
      end
      nwsp_pkg::CMD_PASS_START: begin
        k_r       <= '0;
        changed_r <= 1'b0;
      end
      nwsp_pkg::CMD_PASS_NEXT: begin
        pass_r <= pass_r + NW'(1);
      end
      nwsp_pkg::CMD_EDGE_READ: begin
        k_r <= k_r + CW'(1);
      end
      nwsp_pkg::CMD_POT_READ: begin
        in_rng_r <= (CNTW'(e_tail) < n_w) && (CNTW'(e_head) < n_w);
      end
      nwsp_pkg::CMD_BF_RELAX: begin
        if (improve) begin
          changed_r <= 1'b1;
        end
      end
      nwsp_pkg::CMD_DJ_INIT: begin
        reached_r <= MAX_VERTICES'(1) << VW'(src_r);
        fin_r     <= '0;
      end
      nwsp_pkg::CMD_SCAN_START: begin
        v_r     <= '0;
        found_r <= 1'b0;
      end
      nwsp_pkg::CMD_SCAN_READ: begin
        vq_r <= v_r;
        v_r  <= v_r + VW'(1);
      end
      nwsp_pkg::CMD_SCAN_CMP: begin
        if (scan_take) begin
          best_r   <= vq_r;
          best_d_r <= td_q_r;
          found_r  <= 1'b1;
        end
      end
      nwsp_pkg::CMD_PICK: begin
        fin_r[best_r] <= 1'b1;
        u_r           <= best_r;
        tdu_r         <= best_d_r;
        k_r           <= '0;
      end
      nwsp_pkg::CMD_HEAD_READ: begin
        relax_ok_r <= (tail_ix == u_r) && (CNTW'(e_tail) < n_w)
                      && (CNTW'(e_head) < n_w) && !fin_r[head_ix];
        base_r     <= BW'(tdu_r) + BW'(pot_a_q_r) + BW'(e_w);
      end
      nwsp_pkg::CMD_RELAX: begin
        if (relax_hit) begin
          reached_r[head_ix] <= 1'b1;
        end
      end
      nwsp_pkg::CMD_DIST: begin
        dist_r <= nwsp_pkg::DIST_W'((TW+1)'(td_q_r) - (TW+1)'(pot_a_q_r)
                                    + (TW+1)'(pot_b_q_r));
        cur_r  <= dst_r;
        len_r  <= '0;
      end
      nwsp_pkg::CMD_WALK: begin
        len_r <= len_r + nwsp_pkg::LEN_W'(1);
      end
      nwsp_pkg::CMD_WALK_NEXT: begin
        cur_r <= nwsp_pkg::VERT_W'(pred_q_r);
      end
      nwsp_pkg::CMD_EMIT_READ: begin
        len_r <= len_r - nwsp_pkg::LEN_W'(1);
      end
      nwsp_pkg::CMD_EMIT_LOAD: begin
        out_status_r      <= nwsp_pkg::ST_OK;
        out_distance_r    <= dist_r;
        out_path_vertex_r <= pv_q_r;
        out_last_r        <= (len_r == '0);
      end
      default: begin
      end
    endcase
  end

  assign out_status      = out_status_r;
  assign out_distance    = out_distance_r;
  assign out_path_vertex = out_path_vertex_r;
  assign out_last        = out_last_r;

endmodule

@@ hw/rtl/nwsp_ctrl.sv @@
// sequencing state machine for load, bellman-ford, dijkstra and path output
module nwsp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_opcode,
  input  logic               out_stall,
  input  nwsp_pkg::dp_stat_t stat,
  output logic               in_stall,
  output logic               out_valid,
  output nwsp_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_BF_INIT,
    S_PASS_START,
    S_BF_EDGE,
    S_BF_POT,
    S_BF_UPD,
    S_PASS_END,
    S_SCAN_START,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_PICK,
    S_DJ_EDGE,
    S_DJ_HEAD,
    S_DJ_RELAX,
    S_PATH_DIST,
    S_WALK,
    S_WALK_NEXT,
    S_EMIT_RD,
    S_EMIT_LOAD,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and command
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = nwsp_pkg::CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd = nwsp_pkg::CMD_ACCEPT;
          if (in_opcode == nwsp_pkg::OP_QUERY) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.bad) begin
          cmd           = nwsp_pkg::CMD_SET_BAD;
          state_nxt     = S_OUT;
          out_valid_nxt = 1'b1;
        end else begin
          cmd       = nwsp_pkg::CMD_BF_START;
          state_nxt = S_BF_INIT;
        end
      end
      S_BF_INIT: begin
        cmd = nwsp_pkg::CMD_POT_CLEAR;
        if (stat.v_last) begin
          state_nxt = S_PASS_START;
        end
      end
      S_PASS_START: begin
        cmd       = nwsp_pkg::CMD_PASS_START;
        state_nxt = S_BF_EDGE;
      end
      S_BF_EDGE: begin
        if (stat.k_end) begin
          state_nxt = S_PASS_END;
        end else begin
          cmd       = nwsp_pkg::CMD_EDGE_READ;
          state_nxt = S_BF_POT;
        end
      end
      S_BF_POT: begin
        cmd       = nwsp_pkg::CMD_POT_READ;
        state_nxt = S_BF_UPD;
      end
      S_BF_UPD: begin
        if (stat.improve && stat.pass_final) begin
          cmd           = nwsp_pkg::CMD_SET_NEGCYC;
          state_nxt     = S_OUT;
          out_valid_nxt = 1'b1;
        end else begin
          cmd       = nwsp_pkg::CMD_BF_RELAX;
          state_nxt = S_BF_EDGE;
        end
      end
      S_PASS_END: begin
        if (stat.changed) begin
          cmd       = nwsp_pkg::CMD_PASS_NEXT;
          state_nxt = S_PASS_START;
        end else begin
          cmd       = nwsp_pkg::CMD_DJ_INIT;
          state_nxt = S_SCAN_START;
        end
      end
      S_SCAN_START: begin
        cmd       = nwsp_pkg::CMD_SCAN_START;
        state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd       = nwsp_pkg::CMD_SCAN_READ;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd       = nwsp_pkg::CMD_SCAN_CMP;
        state_nxt = stat.scan_last ? S_PICK : S_SCAN_RD;
      end
      S_PICK: begin
        if (stat.found) begin
          cmd       = nwsp_pkg::CMD_PICK;
          state_nxt = S_DJ_EDGE;
        end else if (stat.unreached) begin
          cmd           = nwsp_pkg::CMD_SET_UNREACH;
          state_nxt     = S_OUT;
          out_valid_nxt = 1'b1;
        end else begin
          cmd       = nwsp_pkg::CMD_PATH_READ;
          state_nxt = S_PATH_DIST;
        end
      end
      S_DJ_EDGE: begin
        if (stat.k_end) begin
          state_nxt = S_SCAN_START;
        end else begin
          cmd       = nwsp_pkg::CMD_EDGE_READ;
          state_nxt = S_DJ_HEAD;
        end
      end
      S_DJ_HEAD: begin
        cmd       = nwsp_pkg::CMD_HEAD_READ;
        state_nxt = S_DJ_RELAX;
      end
      S_DJ_RELAX: begin
        cmd       = nwsp_pkg::CMD_RELAX;
        state_nxt = S_DJ_EDGE;
      end
      S_PATH_DIST: begin
        cmd       = nwsp_pkg::CMD_DIST;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd       = nwsp_pkg::CMD_WALK;
        state_nxt = stat.walk_done ? S_EMIT_RD : S_WALK_NEXT;
      end
      S_WALK_NEXT: begin
        cmd       = nwsp_pkg::CMD_WALK_NEXT;
        state_nxt = S_WALK;
      end
      S_EMIT_RD: begin
        cmd       = nwsp_pkg::CMD_EMIT_READ;
        state_nxt = S_EMIT_LOAD;
      end
      S_EMIT_LOAD: begin
        cmd           = nwsp_pkg::CMD_EMIT_LOAD;
        state_nxt     = S_OUT;
        out_valid_nxt = 1'b1;
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = stat.out_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // state and registered valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
